### rtl/llsgd_pkg.sv
package llsgd_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 12;
  localparam int ACC_W     = 48;
  localparam int LR_W      = 16;
  localparam int NUM_W     = 6;
  localparam int DIV_STEPS = ACC_W;
  localparam int MAC_PRED  = 3;
  localparam int MAC_LAST  = 9;
  localparam int CNT_W     = 6;
  localparam int SEL_W     = 4;
  localparam int IDX_W     = 3;

  // register indexes
  localparam logic [2:0] REG_LR = 3'd6;
  localparam logic [2:0] REG_BS = 3'd7;

  // command codes
  localparam logic CMD_RELOAD = 1'b1;

  localparam logic [NUM_W-1:0][DATA_W-1:0] INIT_RESET = {
    16'hFCCD, 16'h019A, 16'h0666, 16'h0333, 16'hFB33, 16'h0800
  };
  localparam logic [LR_W-1:0] LR_RESET = 16'd655;
  localparam logic [7:0]      BS_RESET = 8'd2;

  typedef struct packed {
    logic [NUM_W-1:0][DATA_W-1:0] init;
    logic [LR_W-1:0]              lr;
    logic [7:0]                   bs;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RELOAD,
    OP_MAC,
    OP_PRED,
    OP_COUNT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MEAN,
    OP_SCL_LO,
    OP_SCL_HI,
    OP_WB,
    OP_BDONE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic batch_end;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RELOAD,
    S_MAC,
    S_PRED,
    S_CHK,
    S_DINIT,
    S_DIV,
    S_MEAN,
    S_SLO,
    S_SHI,
    S_WB,
    S_BDONE,
    S_FIN
  } state_t;

  // saturate a wide signed value to the data width
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [37:0] v);
    logic signed [37:0] hi;
    logic signed [37:0] lo;
    hi = 38'sd32767;
    lo = -38'sd32768;
    if (v > hi) begin
      sat_data = 16'sh7FFF;
    end else if (v < lo) begin
      sat_data = 16'sh8000;
    end else begin
      sat_data = v[DATA_W-1:0];
    end
  endfunction

endpackage

### rtl/llsgd_cfg.sv
module llsgd_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output llsgd_pkg::cfg_t     cfg
);

  llsgd_pkg::cfg_t cfg_r;
  logic [2:0]      idx;
  logic            wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init <= llsgd_pkg::INIT_RESET;
      cfg_r.lr   <= llsgd_pkg::LR_RESET;
      cfg_r.bs   <= llsgd_pkg::BS_RESET;
    end else if (wr) begin
      unique case (idx)
        llsgd_pkg::REG_LR: cfg_r.lr <= pwdata[15:0];
        llsgd_pkg::REG_BS: cfg_r.bs <= pwdata[7:0];
        default:           cfg_r.init[idx] <= pwdata[15:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      llsgd_pkg::REG_LR: prdata = {16'd0, cfg_r.lr};
      llsgd_pkg::REG_BS: prdata = {24'd0, cfg_r.bs};
      default:           prdata = {16'd0, cfg_r.init[idx]};
    endcase
  end

endmodule

### rtl/llsgd_ctrl.sv
module llsgd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_cmd,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  llsgd_pkg::stat_t   stat,
  output llsgd_pkg::cmd_t    cmd
);

  llsgd_pkg::state_t             state_r, state_nxt;
  logic [llsgd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [llsgd_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                          ovld_r, ovld_nxt;

  assign out_tvalid = ovld_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llsgd_pkg::S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ovld_nxt  = ovld_r && !out_tready;
    in_tready = 1'b0;
    cmd.op    = llsgd_pkg::OP_NONE;
    cmd.sel   = '0;
    unique case (state_r)
      llsgd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op  = llsgd_pkg::OP_LOAD;
          cnt_nxt = '0;
          state_nxt = (in_cmd == llsgd_pkg::CMD_RELOAD) ? llsgd_pkg::S_RELOAD
                                                        : llsgd_pkg::S_MAC;
        end
      end
      llsgd_pkg::S_RELOAD: begin
        cmd.op    = llsgd_pkg::OP_RELOAD;
        state_nxt = llsgd_pkg::S_FIN;
      end
      llsgd_pkg::S_MAC: begin
        cmd.op  = llsgd_pkg::OP_MAC;
        cmd.sel = cnt_r[llsgd_pkg::SEL_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == llsgd_pkg::CNT_W'(llsgd_pkg::MAC_PRED)) begin
          state_nxt = llsgd_pkg::S_PRED;
        end else if (cnt_r == llsgd_pkg::CNT_W'(llsgd_pkg::MAC_LAST)) begin
          state_nxt = llsgd_pkg::S_CHK;
        end
      end
      llsgd_pkg::S_PRED: begin
        cmd.op    = llsgd_pkg::OP_PRED;
        state_nxt = llsgd_pkg::S_MAC;
      end
      llsgd_pkg::S_CHK: begin
        idx_nxt = '0;
        if (stat.batch_end) begin
          state_nxt = llsgd_pkg::S_DINIT;
        end else begin
          cmd.op    = llsgd_pkg::OP_COUNT;
          state_nxt = llsgd_pkg::S_FIN;
        end
      end
      llsgd_pkg::S_DINIT: begin
        cmd.op    = llsgd_pkg::OP_DIV_INIT;
        cmd.sel   = {1'b0, idx_r};
        cnt_nxt   = '0;
        state_nxt = llsgd_pkg::S_DIV;
      end
      llsgd_pkg::S_DIV: begin
        cmd.op  = llsgd_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == llsgd_pkg::CNT_W'(llsgd_pkg::DIV_STEPS - 1)) begin
          state_nxt = llsgd_pkg::S_MEAN;
        end
      end
      llsgd_pkg::S_MEAN: begin
        cmd.op    = llsgd_pkg::OP_MEAN;
        state_nxt = llsgd_pkg::S_SLO;
      end
      llsgd_pkg::S_SLO: begin
        cmd.op    = llsgd_pkg::OP_SCL_LO;
        state_nxt = llsgd_pkg::S_SHI;
      end
      llsgd_pkg::S_SHI: begin
        cmd.op    = llsgd_pkg::OP_SCL_HI;
        state_nxt = llsgd_pkg::S_WB;
      end
      llsgd_pkg::S_WB: begin
        cmd.op  = llsgd_pkg::OP_WB;
        cmd.sel = {1'b0, idx_r};
        if (idx_r == llsgd_pkg::IDX_W'(llsgd_pkg::NUM_W - 1)) begin
          state_nxt = llsgd_pkg::S_BDONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = llsgd_pkg::S_DINIT;
        end
      end
      llsgd_pkg::S_BDONE: begin
        cmd.op    = llsgd_pkg::OP_BDONE;
        state_nxt = llsgd_pkg::S_FIN;
      end
      llsgd_pkg::S_FIN: begin
        if (!ovld_r || out_tready) begin
          cmd.op    = llsgd_pkg::OP_OUT;
          ovld_nxt  = 1'b1;
          state_nxt = llsgd_pkg::S_IDLE;
        end
      end
      default: state_nxt = llsgd_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/llsgd_dp.sv
module llsgd_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  llsgd_pkg::cfg_t     cfg,
  input  llsgd_pkg::cmd_t     cmd,
  output llsgd_pkg::stat_t    stat,
  input  logic [63:0]         in_data,
  output logic [159:0]        out_data,
  output logic                out_done
);

  logic signed [15:0] x0_r, x1_r, t0_r, t1_r;
  logic signed [15:0] w_r [llsgd_pkg::NUM_W];
  logic signed [47:0] acc_r [llsgd_pkg::NUM_W];
  logic signed [33:0] s0_r, s1_r;
  logic signed [15:0] p0_r, p1_r;
  logic signed [16:0] e0_r, e1_r;
  logic [32:0]        lsum_r;
  logic [7:0]         scnt_r;
  logic               done_r;
  logic [47:0]        q_r;
  logic [7:0]         rem_r;
  logic               neg_r;
  logic signed [47:0] mean_r;
  logic signed [63:0] scl_r;
  logic [159:0]       odata_r;
  logic               odone_r;

  logic signed [24:0] ma;
  logic signed [17:0] mb;
  logic signed [42:0] mp;
  logic [8:0]         n9;
  logic [8:0]         eff;
  logic signed [33:0] r0, r1;
  logic signed [15:0] p0, p1;
  logic signed [16:0] e0, e1;
  logic [8:0]         dsh;
  logic signed [47:0] dsrc;
  logic signed [63:0] rnd;
  logic signed [35:0] stp;
  logic [2:0]         si;

  assign si       = cmd.sel[2:0];
  assign out_data = odata_r;
  assign out_done = odone_r;

  // batch end check
  assign n9  = {1'b0, scnt_r} + 9'd1;
  assign eff = (cfg.bs == 8'd0) ? 9'd1 : {1'b0, cfg.bs};
  assign stat.batch_end = (n9 >= eff);

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      llsgd_pkg::OP_MAC: begin
        case (cmd.sel)
          4'd0: begin ma = 25'(w_r[0]); mb = 18'(x0_r); end
          4'd1: begin ma = 25'(w_r[1]); mb = 18'(x1_r); end
          4'd2: begin ma = 25'(w_r[2]); mb = 18'(x0_r); end
          4'd3: begin ma = 25'(w_r[3]); mb = 18'(x1_r); end
          4'd4: begin ma = 25'(e0_r);   mb = 18'(e0_r); end
          4'd5: begin ma = 25'(e1_r);   mb = 18'(e1_r); end
          4'd6: begin ma = 25'(e0_r);   mb = 18'(x0_r); end
          4'd7: begin ma = 25'(e0_r);   mb = 18'(x1_r); end
          4'd8: begin ma = 25'(e1_r);   mb = 18'(x0_r); end
          4'd9: begin ma = 25'(e1_r);   mb = 18'(x1_r); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      llsgd_pkg::OP_SCL_LO: begin
        ma = $signed({1'b0, mean_r[23:0]});
        mb = $signed({2'b00, cfg.lr});
      end
      llsgd_pkg::OP_SCL_HI: begin
        ma = 25'($signed(mean_r[47:24]));
        mb = $signed({2'b00, cfg.lr});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign mp = ma * mb;

  // prediction rounding, saturation and error
  assign r0 = s0_r + $signed({{2{w_r[4][15]}}, w_r[4], 12'd0}) + 34'sd2048;
  assign r1 = s1_r + $signed({{2{w_r[5][15]}}, w_r[5], 12'd0}) + 34'sd2048;
  assign p0 = llsgd_pkg::sat_data(38'($signed(r0[33:12])));
  assign p1 = llsgd_pkg::sat_data(38'($signed(r1[33:12])));
  assign e0 = 17'(p0) - 17'(t0_r);
  assign e1 = 17'(p1) - 17'(t1_r);

  // divider shift and rounding of the scaled step
  assign dsh  = {rem_r, q_r[47]};
  assign dsrc = acc_r[si];
  assign rnd  = scl_r + 64'sd134217728;
  assign stp  = rnd[63:28];

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < llsgd_pkg::NUM_W; i++) begin
        w_r[i]   <= llsgd_pkg::INIT_RESET[i];
        acc_r[i] <= '0;
      end
      scnt_r  <= '0;
      done_r  <= 1'b0;
      odone_r <= 1'b0;
    end else begin
      case (cmd.op)
        llsgd_pkg::OP_LOAD: begin
          x0_r   <= in_data[15:0];
          x1_r   <= in_data[31:16];
          t0_r   <= in_data[47:32];
          t1_r   <= in_data[63:48];
          done_r <= 1'b0;
        end
        llsgd_pkg::OP_RELOAD: begin
          for (int i = 0; i < llsgd_pkg::NUM_W; i++) begin
            w_r[i]   <= cfg.init[i];
            acc_r[i] <= '0;
          end
          scnt_r <= '0;
          p0_r   <= '0;
          p1_r   <= '0;
          lsum_r <= '0;
          done_r <= 1'b0;
        end
        llsgd_pkg::OP_MAC: begin
          case (cmd.sel)
            4'd0: s0_r <= 34'(mp);
            4'd1: s0_r <= s0_r + 34'(mp);
            4'd2: s1_r <= 34'(mp);
            4'd3: s1_r <= s1_r + 34'(mp);
            4'd4: lsum_r <= 33'(mp);
            4'd5: lsum_r <= lsum_r + 33'(mp);
            4'd6: acc_r[0] <= acc_r[0] + 48'(mp);
            4'd7: acc_r[1] <= acc_r[1] + 48'(mp);
            4'd8: acc_r[2] <= acc_r[2] + 48'(mp);
            4'd9: acc_r[3] <= acc_r[3] + 48'(mp);
            default: ;
          endcase
        end
        llsgd_pkg::OP_PRED: begin
          p0_r     <= p0;
          p1_r     <= p1;
          e0_r     <= e0;
          e1_r     <= e1;
          acc_r[4] <= acc_r[4] + $signed({{19{e0[16]}}, e0, 12'd0});
          acc_r[5] <= acc_r[5] + $signed({{19{e1[16]}}, e1, 12'd0});
        end
        llsgd_pkg::OP_COUNT: scnt_r <= n9[7:0];
        llsgd_pkg::OP_DIV_INIT: begin
          neg_r <= dsrc[47];
          q_r   <= dsrc[47] ? 48'(-dsrc) : 48'(dsrc);
          rem_r <= '0;
        end
        llsgd_pkg::OP_DIV_STEP: begin
          if (dsh >= n9) begin
            rem_r <= 8'(dsh - n9);
            q_r   <= {q_r[46:0], 1'b1};
          end else begin
            rem_r <= dsh[7:0];
            q_r   <= {q_r[46:0], 1'b0};
          end
        end
        llsgd_pkg::OP_MEAN: mean_r <= neg_r ? -$signed(q_r) : $signed(q_r);
        llsgd_pkg::OP_SCL_LO: scl_r <= 64'(mp);
        llsgd_pkg::OP_SCL_HI: scl_r <= scl_r + (64'(mp) <<< 24);
        llsgd_pkg::OP_WB: begin
          w_r[si]   <= llsgd_pkg::sat_data(38'(w_r[si]) - 38'(stp));
          acc_r[si] <= '0;
        end
        llsgd_pkg::OP_BDONE: begin
          scnt_r <= '0;
          done_r <= 1'b1;
        end
        llsgd_pkg::OP_OUT: begin
          odata_r <= {w_r[5], w_r[4], w_r[3], w_r[2], w_r[1], w_r[0],
                      lsum_r[32:1], p1_r, p0_r};
          odone_r <= done_r;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/linear_layer_sgd_trainer_core.sv
// Linear layer trainer: two inputs, two outputs, minibatch gradient descent.
// Input stream: in_tdata carries x_first, x_second, target_first,
// target_second (Q4.12); in_tuser is the command (0 train, 1 reload).
// Result stream: one transaction per input with both predictions, the loss,
// batch_done in out_tuser and the six weights after the item.
// Configuration: APB registers for initial weights, learning rate, batch size.
// Items are handled one at a time through a single shared multiplier.
// A train item runs ten multiplies with a rounding step after the fourth, a
// batch check and output, and the next item can be accepted in the cycle
// out_tvalid rises; a reload runs the weight reload and then output.
// An item that completes a batch then runs, per weight, a divider load, a
// bit-serial divide of the 48-bit accumulator by the sample count, a sign fix,
// two multiplies for the learning rate scaling and a write-back, repeated six
// times, and finally a step that flags the batch.
// Reset loads the initial register reset values into the weights, clears the
// accumulators and sample count and empties the output register.
// The next item is accepted while a result waits in the output register; if
// the receiver still stalls when the following result is done, the block
// holds in its final state until out_tready.
module linear_layer_sgd_trainer_core (
  input  logic          clk,
  input  logic          rst_n,
  // x_first, x_second, target_first, target_second
  input  logic [63:0]   in_tdata,
  // command
  input  logic [0:0]    in_tuser,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pred_first, pred_second, loss_value, weight_00, weight_01, weight_10,
  // weight_11, bias_0, bias_1
  output logic [159:0]  out_tdata,
  // batch_done
  output logic [0:0]    out_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [4:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  llsgd_pkg::cfg_t  cfg;
  llsgd_pkg::cmd_t  cmd;
  llsgd_pkg::stat_t stat;

  // configuration registers
  llsgd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer
  llsgd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic and state
  llsgd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_tdata),
    .out_data (out_tdata),
    .out_done (out_tuser[0])
  );

endmodule

### rtl/llsgd_checker.sv
module llsgd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic         cfg_pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed under stall");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // no result can come out the cycle after an accept
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind linear_layer_sgd_trainer_core llsgd_checker u_llsgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
